// ===== sv/grid_wall_follower_defines.svh =====
// Assertion macros for the grid wall follower.
// Included by the top level; needs nothing else.
`ifndef GRID_WALL_FOLLOWER_DEFINES_SVH
`define GRID_WALL_FOLLOWER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gwf_pkg.sv =====
// Shared types and codes for the grid wall follower.
// No dependencies; used by the interfaces and the top level.
package gwf_pkg;

	typedef logic [1:0] action_t;
	typedef logic [1:0] cell_t;
	typedef logic [1:0] dir_t;
	typedef logic [7:0] byte_t;

	localparam int POS_W = 6;
	typedef logic [POS_W-1:0] pos_t;

	localparam action_t ACT_LOAD  = 2'd0;
	localparam action_t ACT_STEP  = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

	localparam cell_t CELL_WALL  = 2'd0;
	localparam cell_t CELL_OPEN  = 2'd1;
	localparam cell_t CELL_START = 2'd2;
	localparam cell_t CELL_END   = 2'd3;

	localparam dir_t DIR_RIGHT = 2'd0;
	localparam dir_t DIR_UP    = 2'd1;
	localparam dir_t DIR_LEFT  = 2'd2;
	localparam dir_t DIR_DOWN  = 2'd3;

	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_NL    = 8'h0A;
	localparam byte_t CH_OPEN  = 8'h20;
	localparam byte_t CH_END   = 8'h45;
	localparam byte_t CH_START = 8'h53;

	// Probe 0 is the walker's own cell, probes 1 to 4 are right, straight, left, back.
	typedef logic [2:0] probe_t;
	localparam probe_t PROBE_CUR  = 3'd0;
	localparam probe_t PROBE_LAST = 3'd4;

	function automatic cell_t char_to_cell(input byte_t b);
		cell_t c;
		case (b)
			CH_START: c = CELL_START;
			CH_END:   c = CELL_END;
			CH_OPEN:  c = CELL_OPEN;
			default:  c = CELL_WALL;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/gwf_cmd_if.sv =====
// Request channel of the grid wall follower: action and load byte.
// Depends on gwf_pkg.
interface gwf_cmd_if;
	logic             valid;
	logic             ready;
	gwf_pkg::action_t action;
	gwf_pkg::byte_t   byte_value;

	modport source (output valid, output action, output byte_value, input ready);
	modport sink (input valid, input action, input byte_value, output ready);
endinterface

// ===== sv/gwf_rsp_if.sv =====
// Result channel of the grid wall follower: one result per step request.
// Depends on gwf_pkg.
interface gwf_rsp_if;
	logic          valid;
	logic          ready;
	gwf_pkg::dir_t move;
	logic          moved;
	logic          at_end;
	gwf_pkg::pos_t pos_x;
	gwf_pkg::pos_t pos_y;

	modport source (output valid, output move, output moved, output at_end,
		output pos_x, output pos_y, input ready);
	modport sink (input valid, input move, input moved, input at_end,
		input pos_x, input pos_y, output ready);
endinterface

// ===== sv/grid_wall_follower.sv =====
// Grid wall follower: maze loader and right-hand-rule walker over one cell memory.
// Depends on gwf_pkg, gwf_cmd_if, gwf_rsp_if and grid_wall_follower_defines.svh.
//
//   channel | dir | payload
//   cmd     | in  | action, byte_value
//   rsp     | out | move, moved, at_end, pos_x, pos_y
//
// Load, clear and unused requests are done when accepted; they write at most one cell.
// A step does one cell-memory read per probe (own cell, then up to four neighbors in
// right, straight, left, back order) through one registered read port.
// A finished result sits in an output register; loads and clears go on while it waits,
// and a later step holds its last probe until that register is free.
// Reset clears all control state; the cell memory keeps its contents.
`include "grid_wall_follower_defines.svh"

module grid_wall_follower #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input logic        clk,
	input logic        arst_n,
	gwf_cmd_if.sink    cmd,
	gwf_rsp_if.source  rsp
);

	localparam int XW = $clog2(MAX_COLS);
	localparam int YW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int AW = XW + YW;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PROBE = 1'b1;

	logic state_q;

	// Load bookkeeping and walker.
	logic [CW-1:0] load_col_q;
	logic [RW-1:0] row_cnt_q;
	logic [CW-1:0] grid_w_q;
	logic          first_row_q;
	logic [XW-1:0] walker_x_q;
	logic [YW-1:0] walker_y_q;
	gwf_pkg::dir_t heading_q;

	// Cell memory.
	gwf_pkg::cell_t mem [2**AW];
	gwf_pkg::cell_t rd_data_q;
	logic [AW-1:0]  rd_addr;
	logic           rd_en;
	logic [AW-1:0]  wr_addr;
	logic           mem_we;
	gwf_pkg::cell_t wr_code;

	// Probe stage, aligned with the memory read data.
	gwf_pkg::probe_t probe_s1;
	logic            ok_s1;
	logic [CW-1:0]   nx_s1;
	logic [RW-1:0]   ny_s1;
	gwf_pkg::dir_t   dir_s1;

	// Output register.
	logic          out_valid_q;
	gwf_pkg::dir_t out_move_q;
	logic          out_moved_q;
	logic          out_at_end_q;
	logic [XW-1:0] out_x_q;
	logic [YW-1:0] out_y_q;

	logic cmd_acc;
	logic out_free;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Grid height: completed rows plus a partly loaded row, capped.
	logic [RW:0]   h_sum;
	logic [RW-1:0] grid_h;
	always_comb begin
		h_sum = (RW+1)'(row_cnt_q) + (RW+1)'(load_col_q != '0);
		if (h_sum > (RW+1)'(MAX_ROWS)) begin
			grid_h = RW'(MAX_ROWS);
		end else begin
			grid_h = h_sum[RW-1:0];
		end
	end

	// Address and in-grid flag of the next probe.
	gwf_pkg::probe_t pn;
	gwf_pkg::dir_t   pd;
	logic [CW-1:0]   nx;
	logic [RW-1:0]   ny;
	logic            ok;
	always_comb begin
		pn = (state_q == ST_IDLE) ? gwf_pkg::PROBE_CUR : probe_s1 + 3'd1;
		pd = heading_q + pn[1:0] + 2'd2;
		nx = CW'(walker_x_q);
		ny = RW'(walker_y_q);
		ok = 1'b0;
		if (pn == gwf_pkg::PROBE_CUR) begin
			ok = (nx < grid_w_q) && (ny < grid_h);
		end else begin
			case (pd)
				gwf_pkg::DIR_RIGHT: begin
					nx = CW'(walker_x_q) + CW'(1);
					ok = (nx < grid_w_q) && (ny < grid_h);
				end
				gwf_pkg::DIR_UP: begin
					ny = RW'(walker_y_q) - RW'(1);
					ok = (walker_y_q != '0) && (nx < grid_w_q) && (ny < grid_h);
				end
				gwf_pkg::DIR_LEFT: begin
					nx = CW'(walker_x_q) - CW'(1);
					ok = (walker_x_q != '0) && (nx < grid_w_q) && (ny < grid_h);
				end
				default: begin
					ny = RW'(walker_y_q) + RW'(1);
					ok = (nx < grid_w_q) && (ny < grid_h);
				end
			endcase
		end
		rd_addr = {ny[YW-1:0], nx[XW-1:0]};
	end

	// Evaluation of the probe whose cell is in rd_data_q.
	logic pass;
	logic fin_end;
	logic fin_move;
	logic fin_box;
	logic out_load;
	always_comb begin
		pass     = ok_s1 && (rd_data_q == gwf_pkg::CELL_OPEN || rd_data_q == gwf_pkg::CELL_END);
		fin_end  = 1'b0;
		fin_move = 1'b0;
		fin_box  = 1'b0;
		if (state_q == ST_PROBE) begin
			if (probe_s1 == gwf_pkg::PROBE_CUR) begin
				fin_end = ok_s1 && (rd_data_q == gwf_pkg::CELL_END);
			end else begin
				fin_move = pass;
				fin_box  = !pass && (probe_s1 == gwf_pkg::PROBE_LAST);
			end
		end
		out_load = (fin_end || fin_move || fin_box) && out_free;
		rd_en    = (cmd_acc && cmd.action == gwf_pkg::ACT_STEP) ||
			(state_q == ST_PROBE && !fin_end && !fin_move && !fin_box);
	end

	// Load write.
	logic is_load;
	always_comb begin
		is_load = cmd_acc && cmd.action == gwf_pkg::ACT_LOAD &&
			cmd.byte_value != gwf_pkg::CH_NUL && cmd.byte_value != gwf_pkg::CH_NL;
		wr_code = gwf_pkg::char_to_cell(cmd.byte_value);
		wr_addr = {row_cnt_q[YW-1:0], load_col_q[XW-1:0]};
		mem_we  = is_load && load_col_q < CW'(MAX_COLS) && row_cnt_q < RW'(MAX_ROWS) &&
			(!first_row_q || load_col_q < grid_w_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_code;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			nx_s1     <= nx;
			ny_s1     <= ny;
			dir_s1    <= pd;
		end
		if (out_load) begin
			out_move_q   <= fin_end ? gwf_pkg::DIR_RIGHT :
				(fin_move ? dir_s1 : heading_q + 2'd2);
			out_moved_q  <= fin_move;
			out_at_end_q <= fin_end || (fin_move && rd_data_q == gwf_pkg::CELL_END);
			out_x_q      <= fin_move ? nx_s1[XW-1:0] : walker_x_q;
			out_y_q      <= fin_move ? ny_s1[YW-1:0] : walker_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_col_q  <= '0;
			row_cnt_q   <= '0;
			grid_w_q    <= '0;
			first_row_q <= 1'b0;
			walker_x_q  <= '0;
			walker_y_q  <= '0;
			heading_q   <= gwf_pkg::DIR_UP;
			probe_s1    <= gwf_pkg::PROBE_CUR;
			ok_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				probe_s1 <= pn;
				ok_s1    <= ok;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						case (cmd.action)
							gwf_pkg::ACT_LOAD: begin
								if (cmd.byte_value == gwf_pkg::CH_NL) begin
									load_col_q  <= '0;
									first_row_q <= 1'b1;
									if (row_cnt_q < RW'(MAX_ROWS)) begin
										row_cnt_q <= row_cnt_q + RW'(1);
									end
								end else if (cmd.byte_value != gwf_pkg::CH_NUL) begin
									if (mem_we) begin
										if (!first_row_q) begin
											grid_w_q <= load_col_q + CW'(1);
										end
										if (wr_code == gwf_pkg::CELL_START) begin
											walker_x_q <= load_col_q[XW-1:0];
											walker_y_q <= row_cnt_q[YW-1:0];
											heading_q  <= gwf_pkg::DIR_UP;
										end
									end
									if (load_col_q < CW'(MAX_COLS)) begin
										load_col_q <= load_col_q + CW'(1);
									end
								end
							end
							gwf_pkg::ACT_STEP: begin
								state_q <= ST_PROBE;
							end
							gwf_pkg::ACT_CLEAR: begin
								load_col_q  <= '0;
								row_cnt_q   <= '0;
								grid_w_q    <= '0;
								first_row_q <= 1'b0;
								walker_x_q  <= '0;
								walker_y_q  <= '0;
								heading_q   <= gwf_pkg::DIR_UP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PROBE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						if (fin_move) begin
							walker_x_q <= nx_s1[XW-1:0];
							walker_y_q <= ny_s1[YW-1:0];
							heading_q  <= dir_s1;
						end else if (fin_box) begin
							heading_q <= heading_q + 2'd2;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.move   = out_move_q;
	assign rsp.moved  = out_moved_q;
	assign rsp.at_end = out_at_end_q;
	assign rsp.pos_x  = gwf_pkg::POS_W'(out_x_q);
	assign rsp.pos_y  = gwf_pkg::POS_W'(out_y_q);

	`GWF_ASSERT_NOW(a_no_write_in_step, clk, arst_n, mem_we, state_q == ST_IDLE, "cell write during a step")
	`GWF_ASSERT_NOW(a_probe_range, clk, arst_n, state_q == ST_PROBE, probe_s1 <= gwf_pkg::PROBE_LAST, "probe index out of range")
	`GWF_ASSERT_NEXT(a_box_reverses, clk, arst_n, out_load && fin_box, heading_q == $past(heading_q) + 2'd2, "boxed-in step did not reverse heading")
	`GWF_ASSERT_NEXT(a_move_changes_pos, clk, arst_n, out_load && fin_move, walker_x_q != $past(walker_x_q) || walker_y_q != $past(walker_y_q), "move left walker in place")

endmodule
